/* rtl/core/mftw_pkg.sv */
// Shared constants, types and the variable-length quantity encoder
// for the MIDI file track writer. No dependencies.

package mftw_pkg;

   // Operation codes of an input item
   localparam logic [1:0] OP_ADVANCE = 2'd0;
   localparam logic [1:0] OP_MESSAGE = 2'd1;
   localparam logic [1:0] OP_START   = 2'd2;
   localparam logic [1:0] OP_STOP    = 2'd3;

   // Defaults for the top level parameters
   localparam int FRAC_BITS_DEFAULT = 24;
   localparam int TPQ_DEFAULT       = 192;

   // Fixed widths and sizes
   localparam int ACC_W       = 56;
   localparam int MAX_RESULTS = 22;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // Fixed bytes of the stream
   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] META_EVENT  = 8'hFF;
   localparam logic [7:0] META_EOT    = 8'h2F;
   localparam logic [7:0] VLQ_MORE    = 8'h80;

   // Up to four VLQ bytes, first byte in entry 0
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } vlq_type;

   // Encode a 28-bit value as a MIDI variable-length quantity
   function automatic vlq_type vlq_encode(input logic [27:0] v);
      vlq_type    r;
      logic [6:0] g3;
      logic [6:0] g2;
      logic [6:0] g1;
      logic [6:0] g0;
      g3 = v[27:21];
      g2 = v[20:14];
      g1 = v[13:7];
      g0 = v[6:0];
      r = '0;
      if (g3 != 7'd0) begin
         r.count    = 3'd4;
         r.bytes[0] = VLQ_MORE | {1'b0, g3};
         r.bytes[1] = VLQ_MORE | {1'b0, g2};
         r.bytes[2] = VLQ_MORE | {1'b0, g1};
         r.bytes[3] = {1'b0, g0};
      end else if (g2 != 7'd0) begin
         r.count    = 3'd3;
         r.bytes[0] = VLQ_MORE | {1'b0, g2};
         r.bytes[1] = VLQ_MORE | {1'b0, g1};
         r.bytes[2] = {1'b0, g0};
      end else if (g1 != 7'd0) begin
         r.count    = 3'd2;
         r.bytes[0] = VLQ_MORE | {1'b0, g1};
         r.bytes[1] = {1'b0, g0};
      end else begin
         r.count    = 3'd1;
         r.bytes[0] = {1'b0, g0};
      end
      return r;
   endfunction

endpackage

/* rtl/core/midi_file_track_writer.sv */
// Single-track Standard MIDI File stream writer: input register, one
// compute stage that loads a result run buffer, and a byte serializer.
// Depends on mftw_pkg.
//
// An item passes the input register and then loads the run buffer, from which
// its first result byte is offered.
// Throughput: one item per cycle while no run is pending; an item that yields
// a run of bytes holds the next item behind it until the one-byte-wide result
// port has drained the run buffer (22 bytes for a start).
// Reset (synchronous, active high) clears recording, time, byte count and the
// ticks-per-frame register; the run buffer contents are not reset.

module midi_file_track_writer #(
   parameter int FRAC_BITS         = mftw_pkg::FRAC_BITS_DEFAULT,
   parameter int TICKS_PER_QUARTER = mftw_pkg::TPQ_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_ticks_per_frame,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [11:0] req_frames,
   input  logic [7:0]  req_data_byte,
   input  logic        req_msg_first,
   input  logic [15:0] req_msg_length,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_length_ready,
   output logic [31:0] rsp_track_length
);
   import mftw_pkg::*;

   localparam int             SUM_W    = ACC_W + 1;
   localparam int             PROD_W   = 44;
   localparam logic [15:0]    DIVISION = 16'(TICKS_PER_QUARTER);
   localparam logic [SUM_W-1:0] HALF   = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic [ACC_W-1:0] ACC_MAX = '1;
   localparam logic [MAX_RESULTS-1:0][7:0] HEADER = {
      8'h00, 8'h00, 8'h00, 8'h00, 8'h6B, 8'h72, 8'h54, 8'h4D,
      DIVISION[7:0], DIVISION[15:8], 8'h01, 8'h00, 8'h00, 8'h00,
      8'h06, 8'h00, 8'h00, 8'h00, 8'h64, 8'h68, 8'h54, 8'h4D
   };

   // configuration register
   logic [31:0] tpf_ff;

   // input register
   logic              a_valid_ff;
   logic [1:0]        a_op_ff;
   logic [PROD_W-1:0] a_prod_ff;
   logic [7:0]        a_data_ff;
   logic              a_first_ff;
   logic [15:0]       a_len_ff;

   // track state
   logic             rec_ff,  rec_in;
   logic [ACC_W-1:0] acc_ff,  acc_in;
   logic [31:0]      last_ff, last_in;
   logic [31:0]      bw_ff,   bw_in;
   logic             skip_ff, skip_in;

   // result run buffer
   logic [MAX_RESULTS-1:0][7:0] byte_buf_ff, byte_buf_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [CNT_W-1:0]            idx_ff;
   logic                        lr_ff, lr_in;
   logic [31:0]                 tl_ff, tl_in;

   logic             run_last;
   logic             burst_free;
   logic             b_load;
   logic [SUM_W-1:0] acc_sum;
   logic [SUM_W-1:0] rnd_sum;
   logic [SUM_W-1:0] rnd_sh;
   logic [SUM_W-1:0] trunc_sh;
   logic [31:0]      now_rnd;
   logic [31:0]      now_trunc;
   logic [31:0]      now_sel;
   logic [31:0]      diff;
   logic [27:0]      delta;
   vlq_type          dv;
   vlq_type          lv;
   logic [15:0]      len_m1;

   assign csr_ready = 1'b1;

   // handshake
   assign rsp_valid  = (cnt_ff != '0);
   assign run_last   = (idx_ff + CNT_W'(1) == cnt_ff);
   assign burst_free = !rsp_valid || (run_last && !rsp_stall);
   assign b_load     = a_valid_ff && burst_free;
   assign req_stall  = a_valid_ff && !burst_free;

   assign rsp_out_byte     = byte_buf_ff[idx_ff];
   assign rsp_run_last     = run_last;
   assign rsp_length_ready = lr_ff;
   assign rsp_track_length = tl_ff;

   // tick arithmetic on the current accumulator
   always_comb begin
      acc_sum   = {1'b0, acc_ff} + SUM_W'(a_prod_ff);
      rnd_sum   = {1'b0, acc_ff} + HALF;
      rnd_sh    = rnd_sum >> FRAC_BITS;
      trunc_sh  = {1'b0, acc_ff} >> FRAC_BITS;
      now_rnd   = (|rnd_sh[SUM_W-1:32]) ? '1 : rnd_sh[31:0];
      now_trunc = (|trunc_sh[SUM_W-1:32]) ? '1 : trunc_sh[31:0];
      now_sel   = (a_op_ff == OP_STOP) ? now_trunc : now_rnd;
      diff      = now_sel - last_ff;
      if (now_sel <= last_ff) begin
         delta = '0;
      end else if (|diff[31:28]) begin
         delta = '1;
      end else begin
         delta = diff[27:0];
      end
      len_m1 = a_len_ff - 16'd1;
      dv     = vlq_encode(delta);
      lv     = vlq_encode({12'd0, len_m1});
   end

   // build the result run and next state for the registered item
   always_comb begin
      logic [CNT_W-1:0] dc;
      logic [CNT_W-1:0] lc;
      logic [CNT_W-1:0] pos;
      logic [CNT_W-1:0] rel;
      logic             is_sysex;
      dc       = CNT_W'(dv.count);
      lc       = CNT_W'(lv.count);
      pos      = '0;
      rel      = '0;
      is_sysex = (a_data_ff == SYSEX_START);
      acc_in   = acc_ff;
      rec_in   = rec_ff;
      last_in  = last_ff;
      bw_in    = bw_ff;
      skip_in  = skip_ff;
      cnt_in   = '0;
      lr_in    = 1'b0;
      tl_in    = '0;
      byte_buf_in = '0;
      case (a_op_ff)
         OP_ADVANCE: begin
            acc_in = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
         end
         OP_START: begin
            byte_buf_in = HEADER;
            cnt_in      = CNT_W'(MAX_RESULTS);
            rec_in      = 1'b1;
            acc_in      = '0;
            last_in     = '0;
            bw_in       = '0;
            skip_in     = 1'b0;
         end
         OP_MESSAGE: begin
            if (rec_ff && a_first_ff && (a_len_ff < 16'd2)) begin
               skip_in = 1'b1;
            end else if (rec_ff && a_first_ff) begin
               skip_in = 1'b0;
               last_in = now_sel;
               cnt_in  = dc + CNT_W'(1) + (is_sysex ? lc : CNT_W'(0));
               for (int i = 0; i < MAX_RESULTS; i++) begin
                  pos = CNT_W'(i);
                  rel = pos - dc - CNT_W'(1);
                  if (pos < dc) begin
                     byte_buf_in[i] = dv.bytes[pos[1:0]];
                  end else if (pos == dc) begin
                     byte_buf_in[i] = a_data_ff;
                  end else if (rel < lc) begin
                     byte_buf_in[i] = lv.bytes[rel[1:0]];
                  end
               end
               bw_in = bw_ff + 32'(cnt_in);
            end else if (rec_ff && !skip_ff) begin
               byte_buf_in[0] = a_data_ff;
               cnt_in         = CNT_W'(1);
               bw_in          = bw_ff + 32'd1;
            end
         end
         OP_STOP: begin
            if (rec_ff) begin
               cnt_in  = dc + CNT_W'(3);
               last_in = now_sel;
               rec_in  = 1'b0;
               for (int i = 0; i < MAX_RESULTS; i++) begin
                  pos = CNT_W'(i);
                  if (pos < dc) begin
                     byte_buf_in[i] = dv.bytes[pos[1:0]];
                  end else if (pos == dc) begin
                     byte_buf_in[i] = META_EVENT;
                  end else if (pos == dc + CNT_W'(1)) begin
                     byte_buf_in[i] = META_EOT;
                  end
               end
               bw_in = bw_ff + 32'(cnt_in);
               lr_in = 1'b1;
               tl_in = bw_in;
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         tpf_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         tpf_ff <= csr_ticks_per_frame;
      end
   end

   // input register, product taken on the way in
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         a_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         a_op_ff    <= req_operation;
         a_prod_ff  <= PROD_W'(req_frames) * PROD_W'(tpf_ff);
         a_data_ff  <= req_data_byte;
         a_first_ff <= req_msg_first;
         a_len_ff   <= req_msg_length;
      end
   end

   // track state advances as the item leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff  <= 1'b0;
         acc_ff  <= '0;
         last_ff <= '0;
         bw_ff   <= '0;
         skip_ff <= 1'b0;
      end else if (b_load) begin
         rec_ff  <= rec_in;
         acc_ff  <= acc_in;
         last_ff <= last_in;
         bw_ff   <= bw_in;
         skip_ff <= skip_in;
      end
   end

   // load a run or advance through it
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (b_load) begin
         cnt_ff <= cnt_in;
         idx_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         if (run_last) begin
            cnt_ff <= '0;
            idx_ff <= '0;
         end else begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
      end
      if (b_load) begin
         byte_buf_ff <= byte_buf_in;
         lr_ff       <= lr_in;
         tl_ff       <= tl_in;
      end
   end

   // checks
   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff < cnt_ff))
      else $error("run index past run length");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> a_valid_ff)
      else $error("input stalled with empty input register");

   a_stop_ends_rec: assert property (@(posedge clock) disable iff (reset)
      (b_load && (a_op_ff == OP_STOP) && rec_ff) |=> !rec_ff)
      else $error("recording still active after stop");

   a_len_only_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_length_ready) |-> (rsp_track_length == 32'd0))
      else $error("track length shown outside a stop run");

   a_start_run_len: assert property (@(posedge clock) disable iff (reset)
      (b_load && (a_op_ff == OP_START)) |=> (cnt_ff == CNT_W'(MAX_RESULTS)))
      else $error("start run is not a full header");

endmodule

/* tb/track_check_pkg.sv */
// Scoreboard for the MIDI file track writer: predicts the file byte stream
// and holds the bytes still to come. Depends on mftw_pkg.

package track_check_pkg;
   import mftw_pkg::*;

   localparam int          FRAC        = FRAC_BITS_DEFAULT;
   localparam logic [27:0] DELTA_LIMIT = 28'hFFF_FFFF;

   // MThd chunk (format 0, one track, division) and an MTrk with a zero size field
   localparam logic [22*8-1:0] FILE_HEADER = {
      8'h4D, 8'h54, 8'h68, 8'h64, 32'd6, 16'd0, 16'd1, 16'(TPQ_DEFAULT),
      8'h4D, 8'h54, 8'h72, 8'h6B, 32'd0};

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        length_ready;
      logic [31:0] track_length;
   } file_byte_type;

   class track_scoreboard;
      logic [31:0]      ticks_per_frame;
      logic             recording;
      logic             skipping;
      logic [ACC_W-1:0] tick_accum;
      logic [31:0]      last_tick;
      logic [31:0]      track_bytes;
      logic [7:0]       run_bytes[$];
      file_byte_type    file_bytes[$];
      int unsigned      mismatches;

      function new();
         ticks_per_frame = '0;
         recording       = 1'b0;
         skipping        = 1'b0;
         tick_accum      = '0;
         last_tick       = '0;
         track_bytes     = '0;
         mismatches      = 0;
      endfunction

      function void write_ticks(logic [31:0] value);
         ticks_per_frame = value;
      endfunction

      function int pending();
         return file_bytes.size();
      endfunction

      // Append a variable-length quantity, leading zero groups dropped
      function void append_vlq(logic [27:0] v);
         int         shift;
         logic [6:0] grp;
         logic       started;
         started = 1'b0;
         for (shift = 21; shift > 0; shift = shift - 7) begin
            grp = v[shift +: 7];
            if (grp != 7'd0 || started) begin
               run_bytes.push_back(VLQ_MORE | {1'b0, grp});
               started = 1'b1;
            end
         end
         run_bytes.push_back({1'b0, v[6:0]});
      endfunction

      // Ticks since the last event, clamped to 0 .. 2^28-1
      function logic [27:0] delta_to(logic [31:0] now);
         logic [31:0] diff;
         if (now <= last_tick)
            return '0;
         diff = now - last_tick;
         return (diff > {4'd0, DELTA_LIMIT}) ? DELTA_LIMIT : diff[27:0];
      endfunction

      // Move the bytes of one item to the expected stream, flag the last
      function void finish_run(logic at_stop);
         file_byte_type b;
         int            i;
         for (i = 0; i < run_bytes.size(); i++) begin
            b.data         = run_bytes[i];
            b.last         = (i == run_bytes.size() - 1);
            b.length_ready = at_stop;
            b.track_length = at_stop ? track_bytes : 32'd0;
            file_bytes.push_back(b);
         end
         run_bytes.delete();
      endfunction

      function void note_item(logic [1:0] op, logic [11:0] frames, logic [7:0] data,
                              logic first, logic [15:0] msg_len);
         logic [63:0] gain;
         logic [63:0] room;
         logic [63:0] tick;
         logic [31:0] now;
         int          k;
         case (op)
            OP_ADVANCE: begin
               // advance time even when idle, hold at full scale
               gain = {52'd0, frames} * {32'd0, ticks_per_frame};
               room = 64'({ACC_W{1'b1}}) - 64'(tick_accum);
               if (gain > room)
                  tick_accum = '1;
               else
                  tick_accum = tick_accum + gain[ACC_W-1:0];
            end
            OP_START: begin
               for (k = 21; k >= 0; k--)
                  run_bytes.push_back(FILE_HEADER[k*8 +: 8]);
               recording   = 1'b1;
               skipping    = 1'b0;
               tick_accum  = '0;
               last_tick   = '0;
               track_bytes = '0;
               finish_run(1'b0);
            end
            OP_MESSAGE: begin
               if (!recording)
                  return;
               if (first) begin
                  // drop one-byte messages whole, delta included
                  if (msg_len < 16'd2) begin
                     skipping = 1'b1;
                     return;
                  end
                  skipping = 1'b0;
                  tick = (64'(tick_accum) + (64'd1 << (FRAC - 1))) >> FRAC;
                  now  = (tick > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tick[31:0];
                  append_vlq(delta_to(now));
                  run_bytes.push_back(data);
                  if (data == SYSEX_START)
                     append_vlq({12'd0, msg_len - 16'd1});
                  last_tick = now;
               end else if (skipping) begin
                  return;
               end else begin
                  run_bytes.push_back(data);
               end
               track_bytes = track_bytes + run_bytes.size();
               finish_run(1'b0);
            end
            default: begin
               if (!recording)
                  return;
               // truncated delta, end of track, length on every byte
               tick = 64'(tick_accum) >> FRAC;
               now  = (tick > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tick[31:0];
               append_vlq(delta_to(now));
               run_bytes.push_back(META_EVENT);
               run_bytes.push_back(META_EOT);
               run_bytes.push_back(8'h00);
               last_tick   = now;
               recording   = 1'b0;
               track_bytes = track_bytes + run_bytes.size();
               finish_run(1'b1);
            end
         endcase
      endfunction

      function void check_byte(file_byte_type got);
         file_byte_type want;
         if (file_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected byte %h last=%b ready=%b length=%0d",
                        got.data, got.last, got.length_ready, got.track_length);
            return;
         end
         want = file_bytes.pop_front();
         if (got.data !== want.data || got.last !== want.last ||
             got.length_ready !== want.length_ready ||
             got.track_length !== want.track_length) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: byte/last/ready/length expected %h/%b/%b/%0d got %h/%b/%b/%0d",
                        want.data, want.last, want.length_ready, want.track_length,
                        got.data, got.last, got.length_ready, got.track_length);
         end
      endfunction
   endclass

endpackage

/* tb/tb.sv */
// Testbench for midi_file_track_writer: directed and random items, random
// stalls on both channels, every output byte checked. Depends on mftw_pkg
// and track_check_pkg.

module tb;
   import mftw_pkg::*;
   import track_check_pkg::*;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 180;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_ticks_per_frame = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = OP_ADVANCE;
   logic [11:0] req_frames = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_msg_first = 1'b0;
   logic [15:0] req_msg_length = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_length_ready;
   logic [31:0] rsp_track_length;

   track_scoreboard sb;
   file_byte_type   seen;
   logic            tx_steady = 1'b0;
   logic            rx_steady = 1'b0;
   logic            rx_hold_request = 1'b0;
   logic            rx_holding = 1'b0;
   int              items_sent = 0;

   midi_file_track_writer uut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_ticks_per_frame (csr_ticks_per_frame),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_frames          (req_frames),
      .req_data_byte       (req_data_byte),
      .req_msg_first       (req_msg_first),
      .req_msg_length      (req_msg_length),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_run_last        (rsp_run_last),
      .rsp_length_ready    (rsp_length_ready),
      .rsp_track_length    (rsp_track_length)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Watch all three handshakes at the clock edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_ticks(csr_ticks_per_frame);
         if (req_valid && !req_stall)
            sb.note_item(req_operation, req_frames, req_data_byte, req_msg_first,
                         req_msg_length);
         if (rsp_valid && !rsp_stall) begin
            seen.data         = rsp_out_byte;
            seen.last         = rsp_run_last;
            seen.length_ready = rsp_length_ready;
            seen.track_length = rsp_track_length;
            sb.check_byte(seen);
         end
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int gap_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 96)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [31:0] phase_ticks(input int idx);
      case (idx % 6)
         0:       return 32'd0;
         1:       return $urandom_range(1, 32'h0100_0000);
         2:       return 32'd134218;   // about 192 ppq at 120 bpm, 48 kHz
         3:       return 32'hFFFF_FFFF;
         4:       return $urandom;
         default: return 32'h0100_0000;
      endcase
   endfunction

   // Receiver: alternate free runs and stalls, take a long hold on request
   initial begin : receiver
      int span;
      int held;
      @(posedge clock);
      forever begin
         if (rx_hold_request) begin
            rx_hold_request = 1'b0;
            rsp_stall <= 1'b1;
            rx_holding = 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(posedge clock);
            rx_holding = 1'b0;
         end
         rsp_stall <= 1'b0;
         span = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
         repeat (span) @(posedge clock);
         span = rx_steady ? 0 : gap_cycles();
         if (span > 0) begin
            rsp_stall <= 1'b1;
            repeat (span) @(posedge clock);
         end
      end
   end

   // Offer one item, wait until taken, then idle for a random gap
   task automatic send_item(input logic [1:0] op, input logic [11:0] frames,
                            input logic [7:0] data, input logic first,
                            input logic [15:0] msg_len);
      int gap;
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_frames     <= frames;
      req_data_byte  <= data;
      req_msg_first  <= first;
      req_msg_length <= msg_len;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      gap = tx_steady ? 0 : gap_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_advance(input logic [11:0] frames);
      send_item(OP_ADVANCE, frames, 8'($urandom), 1'($urandom), 16'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] data, input logic first,
                            input logic [15:0] msg_len);
      send_item(OP_MESSAGE, 12'($urandom), data, first, msg_len);
   endtask

   task automatic send_control(input logic [1:0] op);
      send_item(op, 12'($urandom), 8'($urandom), 1'($urandom), 16'($urandom));
   endtask

   // Hold the sender until every expected byte is out, then let the block drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic load_ticks(input logic [31:0] value);
      csr_valid           <= 1'b1;
      csr_ticks_per_frame <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // One recording: mostly well-formed messages and time, some noise
   task automatic random_phase(input logic [31:0] tpf, input int budget);
      int          phase_end;
      int          pick;
      int          n;
      int          i;
      logic [15:0] len;
      settle();
      load_ticks(tpf);
      tx_steady = ($urandom_range(0, 5) == 0);
      rx_steady = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 7) != 0)
         send_control(OP_START);
      phase_end = items_sent + budget;
      while (items_sent < phase_end) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_advance(12'(($urandom_range(0, 4) == 0) ? $urandom
                                                          : $urandom_range(0, 255)));
         end else if (pick < 72) begin
            // channel message, two or three bytes
            len = 16'($urandom_range(2, 3));
            send_byte(8'($urandom_range(8'h80, 8'hEF)), 1'b1, len);
            for (i = 1; i < len; i++)
               send_byte(8'($urandom_range(0, 127)), 1'b0, 16'($urandom));
         end else if (pick < 84) begin
            // system exclusive: F0, a few body bytes, F7
            len = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(2, 65535)
                                                  : $urandom_range(2, 10));
            send_byte(SYSEX_START, 1'b1, len);
            n = (len > 8) ? 6 : len - 2;
            for (i = 0; i < n; i++)
               send_byte(8'($urandom_range(0, 127)), 1'b0, 16'($urandom));
            send_byte(8'hF7, 1'b0, 16'($urandom));
         end else if (pick < 91) begin
            // one-byte message followed by bytes to drop
            send_byte(8'($urandom_range(8'hF1, 8'hFF)), 1'b1, 16'($urandom_range(0, 1)));
            n = $urandom_range(0, 2);
            for (i = 0; i < n; i++)
               send_byte(8'($urandom), 1'b0, 16'($urandom));
         end else if (pick < 96) begin
            send_byte(8'($urandom), 1'($urandom), 16'($urandom));
         end else if (pick < 98) begin
            send_control(OP_START);
         end else begin
            // pause for every byte, then retune in the middle of the track
            settle();
            load_ticks($urandom_range(0, 32'h0200_0000));
         end
      end
      if ($urandom_range(0, 5) != 0)
         send_control(OP_STOP);
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   initial begin : stimulus
      int phase;
      int target;
      int i;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Idle block, zero ticks per frame from reset
      send_byte(8'h90, 1'b1, 16'd3);
      send_control(OP_STOP);
      send_advance(12'hFFF);
      send_control(OP_START);
      send_byte(8'h00, 1'b0, 16'd0);
      send_byte(8'h90, 1'b1, 16'd3);
      send_byte(8'h3C, 1'b0, 16'd0);
      send_byte(8'hFF, 1'b0, 16'hFFFF);
      send_control(OP_STOP);

      // Full-scale rate: long deltas, long SysEx, short messages, restart
      settle();
      load_ticks(32'hFFFF_FFFF);
      send_control(OP_START);
      send_advance(12'hFFF);
      send_byte(SYSEX_START, 1'b1, 16'hFFFF);
      send_byte(8'hF7, 1'b0, 16'd0);
      send_byte(8'hC0, 1'b1, 16'd1);
      send_byte(8'h55, 1'b0, 16'd0);
      send_byte(8'h80, 1'b1, 16'd0);
      send_byte(8'hB0, 1'b1, 16'd2);
      send_byte(8'h07, 1'b0, 16'd0);
      send_control(OP_START);

      // Half a tick: first byte rounds up, stop truncates below it
      settle();
      load_ticks(32'h0080_0000);
      send_advance(12'd1);
      send_byte(8'h90, 1'b1, 16'd3);
      send_byte(8'h40, 1'b0, 16'd0);
      send_control(OP_STOP);
      send_control(OP_STOP);

      // Grow the accumulator far enough for four-byte deltas
      settle();
      load_ticks(32'hFFFF_FFFF);
      send_control(OP_START);
      tx_steady = 1'b1;
      repeat (24) send_advance(12'hFFF);
      tx_steady = 1'b0;
      send_byte(8'h90, 1'b1, 16'd3);
      send_byte(8'h3C, 1'b0, 16'd0);
      send_advance(12'hFFF);
      send_control(OP_STOP);

      // Hold the receiver off while items keep coming, then pause mid-track
      settle();
      load_ticks(32'd134218);
      send_control(OP_START);
      req_valid <= 1'b0;
      rx_hold_request = 1'b1;
      while (!rx_holding)
         @(posedge clock);
      tx_steady = 1'b1;
      for (i = 0; i < 4; i++) begin
         send_control(OP_START);
         send_advance(12'd300);
         send_byte(8'h90, 1'b1, 16'd3);
         send_byte(8'h40, 1'b0, 16'd0);
         send_byte(8'h70, 1'b0, 16'd0);
      end
      tx_steady = 1'b0;
      settle();
      send_advance(12'd2000);
      send_byte(8'hB0, 1'b1, 16'd3);
      send_byte(8'h40, 1'b0, 16'd0);
      send_byte(8'h7F, 1'b0, 16'd0);
      send_control(OP_STOP);

      target = items_sent + RANDOM_ITEMS;
      phase  = 0;
      while (items_sent < target) begin
         random_phase(phase_ticks(phase), 45);
         phase++;
      end

      settle();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("midi_file_track_writer verification clean");
      else
         $display("midi_file_track_writer verification failed");
      $finish;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("midi_file_track_writer verification failed");
      $finish;
   end

endmodule
